// ===== sv/lfp_pkg.sv =====
`default_nettype none
package lfp_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int ROT_BITS          = 30;
    localparam int TABLE_DEPTH       = 16;
    localparam int DIV_W             = 64;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_PROJECT = 1'b1;

    localparam logic [3:0] SLOT_TRANS = 4'd9;
    localparam logic [3:0] SLOT_MINX  = 4'd12;
    localparam logic [3:0] SLOT_MAXX  = 4'd13;
    localparam logic [3:0] SLOT_MINY  = 4'd14;
    localparam logic [3:0] SLOT_MAXY  = 4'd15;

    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_BASELINE = 3'd4;

    localparam logic [30:0] RST_FOCAL_X  = 31'd34406400;
    localparam logic [30:0] RST_FOCAL_Y  = 31'd34406400;
    localparam logic [31:0] RST_CENTER_X = 32'd20938752;
    localparam logic [31:0] RST_CENTER_Y = 32'd15695872;
    localparam logic [30:0] RST_BASELINE = 31'd2621440;

    typedef logic signed [31:0] t_word;
    typedef logic signed [66:0] t_wide;

    typedef struct packed {
        t_word minx;
        t_word maxx;
        t_word miny;
        t_word maxy;
    } t_bounds;

    typedef struct packed {
        logic       rej;
        logic       neg_u;
        logic       neg_v;
        logic [30:0] den;
        t_bounds    bnd;
    } t_side;

    function automatic t_word sat32(input t_wide x);
        t_word res;
        if (x > t_wide'(32'sh7fffffff)) begin
            res = 32'sh7fffffff;
        end else if (x < -t_wide'(33'sh080000000)) begin
            res = 32'sh80000000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/lfp_in_if.sv =====
`default_nettype none
interface lfp_in_if;
    import lfp_pkg::*;
    logic       valid;
    logic       ready;
    logic       func;
    logic [3:0] entry_index;
    t_word      entry_value;
    t_word      world_x;
    t_word      world_y;
    t_word      world_z;
    modport source (output valid, func, entry_index, entry_value, world_x, world_y, world_z,
                    input ready);
    modport sink (input valid, func, entry_index, entry_value, world_x, world_y, world_z,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/lfp_out_if.sv =====
`default_nettype none
interface lfp_out_if;
    import lfp_pkg::*;
    logic  valid;
    logic  ready;
    logic  in_view;
    t_word proj_u;
    t_word proj_v;
    t_word proj_u_right;
    modport source (output valid, in_view, proj_u, proj_v, proj_u_right, input ready);
    modport sink (input valid, in_view, proj_u, proj_v, proj_u_right, output ready);
endinterface
`default_nettype wire

// ===== sv/landmark_frustum_projection_unit.sv =====
`default_nettype none
// channel | dir | handshake      | payload
// i_in    | in  | valid/ready    | func, entry_index, entry_value, world_x/y/z
// o_out   | out | valid/ready    | in_view, proj_u, proj_v, proj_u_right
// i_cfg   | in  | i_cfg_we only  | i_cfg_idx, i_cfg_data
//
// One item per cycle while the pipeline advances. A project item: products,
// camera sum, focal multiply, 64 restoring divider stages (one quotient bit
// each), two output stages. Load items write the table at acceptance and
// give no result. Active-low sync reset clears valids and table, resets cfg.
// The whole pipeline advances when the output register is empty or taken.
module landmark_frustum_projection_unit import lfp_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lfp_in_if.sink     i_in,
    lfp_out_if.source  o_out,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [31:0] i_cfg_data
);

    logic        r_out_valid;
    logic        en;
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // config
    logic [30:0] r_focal_x, r_focal_y, r_bfx;
    t_word       r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x <= RST_FOCAL_X;
            r_focal_y <= RST_FOCAL_Y;
            r_cx      <= RST_CENTER_X;
            r_cy      <= RST_CENTER_Y;
            r_bfx     <= RST_BASELINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FOCAL_X:  r_focal_x <= i_cfg_data[30:0];
                CFG_FOCAL_Y:  r_focal_y <= i_cfg_data[30:0];
                CFG_CENTER_X: r_cx      <= i_cfg_data;
                CFG_CENTER_Y: r_cy      <= i_cfg_data;
                CFG_BASELINE: r_bfx     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // frame table
    t_word r_tab [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_tab[i] <= '0;
            end
        end else if (i_in.valid && en && i_in.func == FUNC_LOAD) begin
            r_tab[i_in.entry_index] <= i_in.entry_value;
        end
    end

    // stage 1: rotation products
    t_word                  wv [3];
    logic                   r1_valid;
    logic signed [63:0]     r1_prod [9];
    t_word                  r1_trans [3];
    t_bounds                r1_bnd;

    assign wv[0] = i_in.world_x;
    assign wv[1] = i_in.world_y;
    assign wv[2] = i_in.world_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_in.valid && i_in.func == FUNC_PROJECT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_prod[r*3+j] <= 64'(r_tab[4'(r*3+j)]) * 64'(wv[j]);
                end
                r1_trans[r] <= r_tab[SLOT_TRANS + 4'(r)];
            end
            r1_bnd <= '{r_tab[SLOT_MINX], r_tab[SLOT_MAXX], r_tab[SLOT_MINY], r_tab[SLOT_MAXY]};
        end
    end

    // stage 2: camera coordinates
    logic    r2_valid;
    t_word   r2_cam [3];
    t_bounds r2_bnd;
    t_word   n_cam [3];

    always_comb begin
        logic signed [65:0] s;
        logic signed [65:0] sh;
        logic signed [36:0] c;
        for (int r = 0; r < 3; r++) begin
            s  = 66'(r1_prod[r*3]) + 66'(r1_prod[r*3+1]) + 66'(r1_prod[r*3+2]);
            sh = s >>> ROT_BITS;
            c  = 37'(sh) + 37'(r1_trans[r]);
            n_cam[r] = sat32(67'(c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cam <= n_cam;
            r2_bnd <= r1_bnd;
        end
    end

    // stage 3: focal products, divider inputs
    logic [31:0] ax, ay;
    logic        zrej;
    assign ax   = r2_cam[0][31] ? 32'(-r2_cam[0]) : 32'(r2_cam[0]);
    assign ay   = r2_cam[1][31] ? 32'(-r2_cam[1]) : 32'(r2_cam[1]);
    assign zrej = r2_cam[2][31] || r2_cam[2] == '0;

    logic             r_dv_valid [DIV_W+1];
    t_side            r_dv_side  [DIV_W+1];
    logic [DIV_W-1:0] r_nq_u [DIV_W+1];
    logic [DIV_W-1:0] r_nq_v [DIV_W+1];
    logic [DIV_W-1:0] r_nq_r [DIV_W+1];
    logic [30:0]      r_rm_u [DIV_W+1];
    logic [30:0]      r_rm_v [DIV_W+1];
    logic [30:0]      r_rm_r [DIV_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (en) begin
            r_dv_valid[0] <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nq_u[0] <= 64'(r_focal_x) * 64'(ax);
            r_nq_v[0] <= 64'(r_focal_y) * 64'(ay);
            r_nq_r[0] <= 64'(r_bfx) << FRACTION_BITS;
            r_rm_u[0] <= '0;
            r_rm_v[0] <= '0;
            r_rm_r[0] <= '0;
            r_dv_side[0] <= '{zrej, r2_cam[0][31], r2_cam[1][31],
                              zrej ? 31'd1 : r2_cam[2][30:0], r2_bnd};
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_W; k++) begin : g_div
        logic [31:0] tu, tv, tr, dd;
        logic        gu, gv, gr;
        assign dd = {1'b0, r_dv_side[k].den};
        assign tu = {r_rm_u[k], r_nq_u[k][DIV_W-1]};
        assign tv = {r_rm_v[k], r_nq_v[k][DIV_W-1]};
        assign tr = {r_rm_r[k], r_nq_r[k][DIV_W-1]};
        assign gu = tu >= dd;
        assign gv = tv >= dd;
        assign gr = tr >= dd;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_side[k+1] <= r_dv_side[k];
                r_rm_u[k+1] <= gu ? 31'(tu - dd) : tu[30:0];
                r_rm_v[k+1] <= gv ? 31'(tv - dd) : tv[30:0];
                r_rm_r[k+1] <= gr ? 31'(tr - dd) : tr[30:0];
                r_nq_u[k+1] <= {r_nq_u[k][DIV_W-2:0], gu};
                r_nq_v[k+1] <= {r_nq_v[k][DIV_W-2:0], gv};
                r_nq_r[k+1] <= {r_nq_r[k][DIV_W-2:0], gr};
            end
        end
    end

    // stage E1: signed u, v
    t_wide qu, qv;
    logic  r4_valid;
    t_wide r4_u, r4_v;
    t_wide r4_qr;
    t_side r4_side;

    assign qu = $signed({3'b000, r_nq_u[DIV_W]});
    assign qv = $signed({3'b000, r_nq_v[DIV_W]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r_dv_valid[DIV_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_u    <= (r_dv_side[DIV_W].neg_u ? -qu : qu) + 67'(r_cx);
            r4_v    <= (r_dv_side[DIV_W].neg_v ? -qv : qv) + 67'(r_cy);
            r4_qr   <= $signed({3'b000, r_nq_r[DIV_W]});
            r4_side <= r_dv_side[DIV_W];
        end
    end

    // stage E2: bounds, output register
    logic  ok;
    t_wide ur;
    assign ok = !r4_side.rej
             && r4_u >= 67'(r4_side.bnd.minx) && r4_u <= 67'(r4_side.bnd.maxx)
             && r4_v >= 67'(r4_side.bnd.miny) && r4_v <= 67'(r4_side.bnd.maxy);
    assign ur = r4_u - r4_qr;

    logic  r_in_view;
    t_word r_pu, r_pv, r_pur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_view <= ok;
            r_pu      <= ok ? sat32(r4_u) : '0;
            r_pv      <= ok ? sat32(r4_v) : '0;
            r_pur     <= ok ? sat32(ur) : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.in_view      = r_in_view;
    assign o_out.proj_u       = r_pu;
    assign o_out.proj_v       = r_pv;
    assign o_out.proj_u_right = r_pur;

endmodule
`default_nettype wire
